// ----- rtl/aad_pkg.sv -----
`default_nettype none
package aad_pkg;
  localparam int MaxTargetWidth = 1024;
  localparam int MaxSourceDim = 32768;
  localparam int SrcW = 17;   // holds MaxSourceDim
  localparam int DstW = 11;   // holds MaxTargetWidth
  localparam int IdxW = 10;   // line store index
  localparam int SumW = 48;
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] RegSrcW = 4'd0;
  localparam logic [AddrW-1:0] RegSrcH = 4'd4;
  localparam logic [AddrW-1:0] RegDstW = 4'd8;
  localparam logic [AddrW-1:0] RegDstH = 4'd12;

  // divider request passed from the accumulator to the divider
  typedef struct packed {
    logic            sign;
    logic [SumW-1:0] mag;
    logic [31:0]     cnt;
  } div_req_t;
endpackage
`default_nettype wire

// ----- rtl/aad_ram.sv -----
`default_nettype none
module aad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/aad_div.sv -----
`default_nettype none
// Radix-2 restoring divider: q = (mag*32 + cnt) / (2*cnt), one quotient bit a cycle.
module aad_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire aad_pkg::div_req_t req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [19:0]            q_o
);
  localparam int NW = aad_pkg::SumW + 6;
  logic [NW-1:0] num_q, num_d;
  logic [NW:0] rem_q, rem_d;
  logic [33:0] den_q;
  logic [5:0] cnt_q;
  logic sign_q;
  logic [NW:0] trial;

  always_comb begin
    trial = {rem_q[NW-1:0], num_q[NW-1]};
    num_d = {num_q[NW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {{(NW-33){1'b0}}, den_q}) begin
      rem_d = trial - {{(NW-33){1'b0}}, den_q};
      num_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_o <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_o <= 1'b1;
        cnt_q  <= 6'(NW);
        num_q  <= {1'b0, req_i.mag, 5'd0} + {{(NW-32){1'b0}}, req_i.cnt};
        rem_q  <= '0;
        den_q  <= {1'b0, req_i.cnt, 1'b0};
        sign_q <= req_i.sign;
      end else if (busy_o) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_o <= 1'b0;
          done_o <= 1'b1;
          q_o    <= sign_q ? 20'(-num_d) : num_d[19:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/area_average_downscaler.sv -----
`default_nettype none
// A sample that ends no block passes the states accept, line store read and update.
// A block-final sample adds the 54-step serial mean divide and the hand-off to the output
// register, plus any wait while the previous item is still held there.
// After a column block end two block edges are rebuilt; after the last sample of a source
// row, or a restart, all four are.
// Reset (async, active low) loads default registers and runs the edge setup; line store not cleared.
module area_average_downscaler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // elevation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // average[19:0], out_x[29:20], out_y[39:30]
  output logic             m_axis_tlast    // frame_end
);
  localparam int SW = aad_pkg::SrcW;
  localparam int DW = aad_pkg::DstW;
  localparam int IW = aad_pkg::IdxW;
  localparam int MW = aad_pkg::SumW;

  typedef enum logic [3:0] {
    S_RESTART, S_IDLE, S_RD, S_UPD, S_EDGE, S_EWAIT, S_DIV, S_DWAIT, S_OUT
  } state_e;
  state_e st_q;

  logic [15:0] rsw_q, rsh_q;
  logic [10:0] rdw_q, rdh_q;
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      aad_pkg::RegSrcW: prdata = {16'd0, rsw_q};
      aad_pkg::RegSrcH: prdata = {16'd0, rsh_q};
      aad_pkg::RegDstW: prdata = {21'd0, rdw_q};
      aad_pkg::RegDstH: prdata = {21'd0, rdh_q};
      default:          prdata = '0;
    endcase
  end
  logic wr;
  assign wr = psel && penable && pwrite &&
              (paddr == aad_pkg::RegSrcW || paddr == aad_pkg::RegSrcH ||
               paddr == aad_pkg::RegDstW || paddr == aad_pkg::RegDstH);

  // effective sizes
  logic [SW-1:0] sw, sh;
  logic [DW-1:0] dw, dh;
  function automatic logic [SW-1:0] eff_src(input logic [15:0] v);
    if (v == 16'd0) eff_src = SW'(1);
    else if (v > 16'(aad_pkg::MaxSourceDim)) eff_src = SW'(aad_pkg::MaxSourceDim);
    else eff_src = {1'b0, v};
  endfunction
  function automatic logic [DW-1:0] eff_dst(input logic [10:0] v, input logic [SW-1:0] s);
    logic [SW-1:0] hi;
    hi = (s < SW'(aad_pkg::MaxTargetWidth)) ? s : SW'(aad_pkg::MaxTargetWidth);
    if (v == 11'd0) eff_dst = DW'(1);
    else if ({6'd0, v} > hi) eff_dst = hi[DW-1:0];
    else eff_dst = v;
  endfunction
  assign sw = eff_src(rsw_q);
  assign sh = eff_src(rsh_q);
  assign dw = eff_dst(rdw_q, sw);
  assign dh = eff_dst(rdh_q, sh);

  // position state
  logic [SW-1:0] scol_q, srow_q;
  logic [DW-1:0] ocol_q, orow_q;
  logic [SW-1:0] cend_q, rend_q, cstart_q, rstart_q;
  logic signed [31:0] seg_q;
  logic [15:0] elev_q;

  // serial edge divider: floor(i*s/d), all four values after a restart or source row end, else cstart and cend
  logic [1:0] ek_q;       // 0 cstart, 1 cend, 2 rstart, 3 rend
  logic [1:0] elast_q;
  logic [27:0] enum_q;
  logic [DW:0] erem_q;
  logic [5:0] ecnt_q;
  logic [DW-1:0] eden_q;
  logic [DW:0] etrial;
  logic [DW-1:0] ei;
  logic [SW-1:0] es;
  assign etrial = {erem_q[DW-1:0], enum_q[27]};
  always_comb begin
    case (ek_q)
      2'd0: begin ei = ocol_q;           es = sw; end
      2'd1: begin ei = ocol_q + DW'(1);  es = sw; end
      2'd2: begin ei = orow_q;           es = sh; end
      default: begin ei = orow_q + DW'(1); es = sh; end
    endcase
  end

  // line store
  logic ram_we;
  logic [MW-1:0] ram_wd, ram_rd;
  logic [IW-1:0] oc;
  assign oc = ocol_q[IW-1:0];
  aad_ram #(.Width(MW), .Depth(aad_pkg::MaxTargetWidth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(oc), .wdata_i(ram_wd), .raddr_i(oc), .rdata_o(ram_rd)
  );

  logic signed [31:0] seg_new;
  logic col_end, row_end;
  logic signed [MW-1:0] csum, csum_q;
  assign seg_new = seg_q + 32'(signed'(elev_q));
  assign col_end = (scol_q + SW'(1)) >= cend_q;
  assign row_end = (srow_q + SW'(1)) >= rend_q;
  assign csum = ((srow_q == rstart_q) ? '0 : signed'(ram_rd)) + MW'(seg_new);
  assign ram_we = (st_q == S_UPD) && col_end;
  assign ram_wd = csum;

  aad_pkg::div_req_t dreq;
  logic dstart, dbusy, ddone;
  logic [19:0] dq;
  logic [SW-1:0] cwid, chgt;
  assign cwid = cend_q - cstart_q;
  assign chgt = rend_q - rstart_q;
  logic [31:0] cnt_q;
  assign dreq.sign = csum_q[MW-1];
  assign dreq.mag  = csum_q[MW-1] ? MW'(-csum_q) : csum_q;
  assign dreq.cnt  = (cnt_q == 32'd0) ? 32'd1 : cnt_q;
  assign dstart = (st_q == S_DIV);
  aad_div u_div (.clk_i, .rst_ni, .start_i(dstart), .req_i(dreq),
                 .busy_o(dbusy), .done_o(ddone), .q_o(dq));

  logic [DW-1:0] oxo_q, oyo_q;
  logic fend_q;
  assign s_axis_tready = (st_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_RESTART;
      rsw_q <= 16'd18000; rsh_q <= 16'd18000;
      rdw_q <= 11'd1024;  rdh_q <= 11'd1024;
      scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0;
      seg_q <= '0; ek_q <= '0; elast_q <= '0; ecnt_q <= '0;
      m_axis_tvalid <= 1'b0;
      cend_q <= '0; rend_q <= '0; cstart_q <= '0; rstart_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (wr) begin
        case (paddr)
          aad_pkg::RegSrcW: rsw_q <= pwdata[15:0];
          aad_pkg::RegSrcH: rsh_q <= pwdata[15:0];
          aad_pkg::RegDstW: rdw_q <= pwdata[10:0];
          default:          rdh_q <= pwdata[10:0];
        endcase
        st_q <= S_RESTART;
      end else begin
        case (st_q)
          S_RESTART: begin
            scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0; seg_q <= '0;
            ek_q <= 2'd0; elast_q <= 2'd3; st_q <= S_EDGE;
          end
          S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
            elev_q <= s_axis_tdata;
            st_q <= S_RD;
          end
          S_RD: st_q <= S_UPD;
          S_UPD: begin
            csum_q <= csum;
            cnt_q <= 32'(cwid) * 32'(chgt);
            oxo_q <= ocol_q; oyo_q <= orow_q;
            fend_q <= (ocol_q + DW'(1) == dw) && (orow_q + DW'(1) == dh);
            ek_q <= 2'd0;
            if (scol_q + SW'(1) >= sw) begin
              scol_q <= '0; ocol_q <= '0; seg_q <= '0;
              elast_q <= 2'd3;
              if (srow_q + SW'(1) >= sh) begin
                srow_q <= '0; orow_q <= '0;
              end else begin
                srow_q <= srow_q + SW'(1);
                if (srow_q + SW'(1) >= rend_q)
                  orow_q <= (orow_q + DW'(1) >= dh) ? '0 : orow_q + DW'(1);
              end
            end else begin
              scol_q <= scol_q + SW'(1);
              seg_q <= col_end ? '0 : seg_new;
              if (col_end) ocol_q <= (ocol_q + DW'(1) >= dw) ? '0 : ocol_q + DW'(1);
              elast_q <= 2'd1;
            end
            if (col_end && row_end) st_q <= S_DIV;
            else if (col_end || scol_q + SW'(1) >= sw) st_q <= S_EDGE;
            else st_q <= S_IDLE;
          end
          S_DIV: st_q <= S_DWAIT;
          S_DWAIT: if (ddone) st_q <= S_OUT;
          // quotient stays on q_o until the next divide
          S_OUT: if (!m_axis_tvalid) begin
            m_axis_tdata <= {oyo_q[9:0], oxo_q[9:0], dq};
            m_axis_tlast <= fend_q;
            m_axis_tvalid <= 1'b1;
            st_q <= S_EDGE;
          end
          S_EDGE: begin
            enum_q <= 28'(ei) * 28'(es);
            erem_q <= '0; eden_q <= (ek_q[1] ? dh : dw); ecnt_q <= 6'd28;
            st_q <= S_EWAIT;
          end
          S_EWAIT: begin
            enum_q <= {enum_q[26:0], (etrial >= {1'b0, eden_q})};
            erem_q <= (etrial >= {1'b0, eden_q}) ? etrial - {1'b0, eden_q} : etrial;
            ecnt_q <= ecnt_q - 6'd1;
            if (ecnt_q == 6'd1) begin
              case (ek_q)
                2'd0: cstart_q <= SW'({enum_q[26:0], (etrial >= {1'b0, eden_q})});
                2'd1: cend_q   <= SW'({enum_q[26:0], (etrial >= {1'b0, eden_q})});
                2'd2: rstart_q <= SW'({enum_q[26:0], (etrial >= {1'b0, eden_q})});
                default: rend_q <= SW'({enum_q[26:0], (etrial >= {1'b0, eden_q})});
              endcase
              if (ek_q == elast_q) st_q <= S_IDLE;
              else begin ek_q <= ek_q + 2'd1; st_q <= S_EDGE; end
            end
          end
          default: st_q <= S_RESTART;
        endcase
      end
    end
  end

  a_one_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("double accept");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart |-> !dbusy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
